FILE: design/ebf_pkg.sv
package ebf_pkg;

	localparam int LEVEL_W = 16;
	localparam int FRAC_W  = 16;
	localparam int STEP_W  = 10;
	localparam int PCT_W   = 7;
	localparam int MUL_W   = 17;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int CNT_W   = 5;
	localparam int OUT_W   = 32;

	// input item kinds
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_SET_PCT = 3'd1;
	localparam logic [2:0] ACT_STEP_UP = 3'd2;
	localparam logic [2:0] ACT_STEP_DN = 3'd3;
	localparam logic [2:0] ACT_SET_RAW = 3'd4;

	// register indexes
	localparam logic [1:0] REG_MAX_LEVEL = 2'd0;
	localparam logic [1:0] REG_SET_STEPS = 2'd1;
	localparam logic [1:0] REG_ADJ_STEPS = 2'd2;

	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 16'd255;
	localparam logic [STEP_W-1:0]  SET_STEPS_RST = 10'd25;
	localparam logic [STEP_W-1:0]  ADJ_STEPS_RST = 10'd12;

	localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
	localparam logic [LEVEL_W-1:0] DIV_HUNDRED = 16'd100;
	localparam logic [LEVEL_W-1:0] DIV_TWENTY  = 16'd20;
	localparam logic [FRAC_W-1:0]  ROUND_HALF  = 16'h8000;
	localparam logic [MUL_W-1:0]   FRAC_ONE    = 17'h10000;

	// iteration counts minus one
	localparam logic [CNT_W-1:0] MUL_LAST = 5'd16;
	localparam logic [CNT_W-1:0] DIV_LAST = 5'd15;
	localparam logic [CNT_W-1:0] PCT_LAST = 5'd6;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_DIV_R   = 14'b00000000000010,
		ST_MUL_R2  = 14'b00000000000100,
		ST_MUL_R3  = 14'b00000000001000,
		ST_MUL_E   = 14'b00000000010000,
		ST_EASE    = 14'b00000000100000,
		ST_MUL_SP  = 14'b00000001000000,
		ST_DIV_SP  = 14'b00000010000000,
		ST_DIV_ADJ = 14'b00000100000000,
		ST_RAMP    = 14'b00001000000000,
		ST_PCT     = 14'b00010000000000,
		ST_MUL_PC  = 14'b00100000000000,
		ST_DIV_PC  = 14'b01000000000000,
		ST_EMIT    = 14'b10000000000000
	} state_t;

endpackage

FILE: design/eased_brightness_fade.sv
// channel  | signals                                  | fields (low bit up)
// s        | s_tvalid s_tready s_tdata s_tuser        | tdata: value; tuser: action
// m        | m_tvalid m_tready m_tdata                | level, level_strobe, busy_res,
//          |                                          | level_percent, zero pad
// cfg      | cfg_valid cfg_ready cfg_index cfg_data   | register index, write data
//
// one item at a time through a bit-serial shift-add multiplier and a
// restoring divider, one bit per cycle each
// tick during a ramp: a divide and three multiplies, then a multiply and a divide for percent
// set percent: multiply and divide, step: divide, set raw or idle tick: percent steps only
// arst_n clears the control and config registers to their reset values, level 0, no ramp
// a waiting result sits in the output register; the next item is taken meanwhile
module eased_brightness_fade
	import ebf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // value
	input  logic [2:0]          s_tuser,   // action
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,   // level, level_strobe, busy_res, level_percent
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [LEVEL_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic [LEVEL_W-1:0] max_q;
	logic [STEP_W-1:0]  set_steps_q, adj_steps_q;

	logic [LEVEL_W-1:0] cur_q, cur_d, start_q, start_d, target_q, target_d;
	logic [STEP_W-1:0]  idx_q, idx_d, tot_q, tot_d;
	logic               ramp_q, ramp_d;
	logic               m_tvalid_q, m_tvalid_d;

	logic [MUL_W-1:0]   mul_a_q, mul_a_d, mul_hi_q, mul_hi_d, mul_b_q, mul_b_d;
	logic [LEVEL_W-1:0] div_rem_q, div_rem_d, div_dsr_q, div_dsr_d;
	logic [LEVEL_W-1:0] div_quo_q, div_quo_d, dvsr_q, dvsr_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [FRAC_W-1:0]  r_q, r_d;
	logic [LEVEL_W-1:0] cand_q, cand_d;
	logic [2:0]         act_q, act_d;
	logic               strobe_q, strobe_d;
	logic [PCT_W-1:0]   pct_q, pct_d;
	logic [LEVEL_W+1:0] v_q, v_d;
	logic [OUT_W-1:0]   m_tdata_q, m_tdata_d;

	logic [LEVEL_W-1:0] mx;
	logic [STEP_W-1:0]  set_eff, adj_eff, idx_inc;
	logic [MUL_W:0]     mul_sum;
	logic [PROD_W-1:0]  prod;
	logic [FRAC_W:0]    rnd;
	logic [LEVEL_W+1:0] div_trial;
	logic               div_ge;
	logic [LEVEL_W-1:0] div_rem_nx, quot;
	logic               cnt_done, is_mul, is_div, out_free, s_fire, asc;
	logic [LEVEL_W-1:0] diff, step, t_dn, t_adj;
	logic [LEVEL_W:0]   t_up;
	logic [PROD_W-1:0]  base, num;
	logic [FRAC_W-1:0]  r3;
	logic [PCT_W-1:0]   pct_in;

	assign mx      = (max_q == '0) ? 16'd1 : max_q;
	assign set_eff = (set_steps_q == '0) ? 10'd1 : set_steps_q;
	assign adj_eff = (adj_steps_q == '0) ? 10'd1 : adj_steps_q;
	assign idx_inc = idx_q + 10'd1;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign is_mul = (state_q == ST_MUL_R2) || (state_q == ST_MUL_R3) || (state_q == ST_MUL_E) ||
		(state_q == ST_MUL_SP) || (state_q == ST_MUL_PC);
	assign is_div = (state_q == ST_DIV_R) || (state_q == ST_DIV_SP) ||
		(state_q == ST_DIV_ADJ) || (state_q == ST_DIV_PC);
	assign cnt_done = (cnt_q == '0);

	// shift-add multiplier, one multiplier bit per cycle
	assign mul_sum = {1'b0, mul_hi_q} + (mul_b_q[0] ? {1'b0, mul_a_q} : 18'd0);
	assign prod    = {mul_sum, mul_b_q[MUL_W-1:1]};
	assign rnd     = {1'b0, prod[2*FRAC_W-1:FRAC_W]} + {16'd0, prod[FRAC_W-1]};

	// restoring divider, one quotient bit per cycle
	assign div_trial  = {1'b0, div_rem_q, div_dsr_q[LEVEL_W-1]} - {2'b00, dvsr_q};
	assign div_ge     = !div_trial[LEVEL_W+1];
	assign div_rem_nx = div_ge ? div_trial[LEVEL_W-1:0] :
		{div_rem_q[LEVEL_W-2:0], div_dsr_q[LEVEL_W-1]};
	assign quot       = {div_quo_q[LEVEL_W-2:0], div_ge};

	assign asc  = (target_q >= start_q);
	assign diff = asc ? (target_q - start_q) : (start_q - target_q);
	assign r3   = rnd[FRAC_W-1:0];
	assign base = {2'b00, start_q, ROUND_HALF};
	assign num  = asc ? (base + prod) : (base - prod);

	assign step  = (quot == '0) ? 16'd1 : quot;
	assign t_up  = {1'b0, cur_q} + {1'b0, step};
	assign t_dn  = (cur_q > step) ? (cur_q - step) : 16'd0;
	assign t_adj = (act_q == ACT_STEP_UP) ?
		((t_up > {1'b0, mx}) ? mx : t_up[LEVEL_W-1:0]) :
		((t_dn > mx) ? mx : t_dn);

	assign pct_in = (s_tdata > 16'd100) ? PCT_FULL : s_tdata[PCT_W-1:0];

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		start_d    = start_q;
		target_d   = target_q;
		idx_d      = idx_q;
		tot_d      = tot_q;
		ramp_d     = ramp_q;
		m_tvalid_d = m_tvalid_q;
		mul_a_d    = mul_a_q;
		mul_hi_d   = mul_hi_q;
		mul_b_d    = mul_b_q;
		div_rem_d  = div_rem_q;
		div_dsr_d  = div_dsr_q;
		div_quo_d  = div_quo_q;
		dvsr_d     = dvsr_q;
		cnt_d      = cnt_q;
		r_d        = r_q;
		cand_d     = cand_q;
		act_d      = act_q;
		strobe_d   = strobe_q;
		pct_d      = pct_q;
		v_d        = v_q;
		m_tdata_d  = m_tdata_q;

		if (m_tvalid_q && m_tready) begin
			m_tvalid_d = 1'b0;
		end

		if (is_mul) begin
			mul_hi_d = mul_sum[MUL_W:1];
			mul_b_d  = {mul_sum[0], mul_b_q[MUL_W-1:1]};
			cnt_d    = cnt_q - 5'd1;
		end
		if (is_div) begin
			div_rem_d = div_rem_nx;
			div_dsr_d = {div_dsr_q[LEVEL_W-2:0], 1'b0};
			div_quo_d = quot;
			cnt_d     = cnt_q - 5'd1;
		end

		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					act_d    = s_tuser;
					strobe_d = 1'b0;
					state_d  = ST_PCT;
					case (s_tuser)
						ACT_TICK: begin
							if (ramp_q) begin
								idx_d    = idx_inc;
								strobe_d = 1'b1;
								if (idx_inc >= tot_q) begin
									cur_d  = target_q;
									ramp_d = 1'b0;
								end else begin
									div_rem_d = {6'd0, tot_q - idx_inc};
									div_dsr_d = '0;
									dvsr_d    = {6'd0, tot_q};
									cnt_d     = DIV_LAST;
									state_d   = ST_DIV_R;
								end
							end
						end
						ACT_SET_PCT: begin
							mul_a_d  = {1'b0, mx};
							mul_b_d  = {10'd0, pct_in};
							mul_hi_d = '0;
							cnt_d    = MUL_LAST;
							state_d  = ST_MUL_SP;
						end
						ACT_STEP_UP, ACT_STEP_DN: begin
							div_rem_d = '0;
							div_dsr_d = mx;
							dvsr_d    = DIV_TWENTY;
							cnt_d     = DIV_LAST;
							state_d   = ST_DIV_ADJ;
						end
						ACT_SET_RAW: begin
							cur_d    = (s_tdata > mx) ? mx : s_tdata;
							ramp_d   = 1'b0;
							strobe_d = 1'b1;
						end
						default: begin
							strobe_d = 1'b0;
						end
					endcase
				end
			end
			ST_DIV_R: begin
				if (cnt_done) begin
					r_d      = quot;
					mul_a_d  = {1'b0, quot};
					mul_b_d  = {1'b0, quot};
					mul_hi_d = '0;
					cnt_d    = MUL_LAST;
					state_d  = ST_MUL_R2;
				end
			end
			ST_MUL_R2: begin
				if (cnt_done) begin
					mul_a_d  = {1'b0, rnd[FRAC_W-1:0]};
					mul_b_d  = {1'b0, r_q};
					mul_hi_d = '0;
					cnt_d    = MUL_LAST;
					state_d  = ST_MUL_R3;
				end
			end
			ST_MUL_R3: begin
				if (cnt_done) begin
					mul_a_d  = FRAC_ONE - {1'b0, r3};
					mul_b_d  = {1'b0, diff};
					mul_hi_d = '0;
					cnt_d    = MUL_LAST;
					state_d  = ST_MUL_E;
				end
			end
			ST_MUL_E: begin
				if (cnt_done) begin
					v_d     = num[PROD_W-1:FRAC_W];
					state_d = ST_EASE;
				end
			end
			ST_EASE: begin
				cur_d   = (v_q > {2'b00, mx}) ? mx : v_q[LEVEL_W-1:0];
				state_d = ST_PCT;
			end
			ST_MUL_SP: begin
				if (cnt_done) begin
					div_rem_d = prod[2*FRAC_W-1:FRAC_W];
					div_dsr_d = prod[FRAC_W-1:0];
					dvsr_d    = DIV_HUNDRED;
					cnt_d     = DIV_LAST;
					state_d   = ST_DIV_SP;
				end
			end
			ST_DIV_SP: begin
				if (cnt_done) begin
					cand_d  = quot;
					state_d = ST_RAMP;
				end
			end
			ST_DIV_ADJ: begin
				if (cnt_done) begin
					cand_d  = t_adj;
					state_d = ST_RAMP;
				end
			end
			ST_RAMP: begin
				if (cand_q == cur_q) begin
					ramp_d = 1'b0;
				end else begin
					start_d  = cur_q;
					target_d = cand_q;
					idx_d    = '0;
					tot_d    = (act_q == ACT_SET_PCT) ? set_eff : adj_eff;
					ramp_d   = 1'b1;
				end
				state_d = ST_PCT;
			end
			ST_PCT: begin
				if (cur_q >= mx) begin
					pct_d   = PCT_FULL;
					state_d = ST_EMIT;
				end else begin
					mul_a_d  = {1'b0, cur_q};
					mul_b_d  = {10'd0, PCT_FULL};
					mul_hi_d = '0;
					cnt_d    = MUL_LAST;
					state_d  = ST_MUL_PC;
				end
			end
			ST_MUL_PC: begin
				if (cnt_done) begin
					div_rem_d = prod[22:7];
					div_dsr_d = {prod[6:0], 9'd0};
					dvsr_d    = mx;
					cnt_d     = PCT_LAST;
					state_d   = ST_DIV_PC;
				end
			end
			ST_DIV_PC: begin
				if (cnt_done) begin
					pct_d   = quot[PCT_W-1:0];
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata_d  = {7'd0, pct_q, ramp_q, strobe_q, cur_q};
					m_tvalid_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_q       <= MAX_LEVEL_RST;
			set_steps_q <= SET_STEPS_RST;
			adj_steps_q <= ADJ_STEPS_RST;
			cur_q       <= '0;
			start_q     <= '0;
			target_q    <= '0;
			idx_q       <= '0;
			tot_q       <= 10'd1;
			ramp_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_q      <= cur_d;
			start_q    <= start_d;
			target_q   <= target_d;
			idx_q      <= idx_d;
			tot_q      <= tot_d;
			ramp_q     <= ramp_d;
			m_tvalid_q <= m_tvalid_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_LEVEL: max_q       <= cfg_data;
					REG_SET_STEPS: set_steps_q <= cfg_data[STEP_W-1:0];
					REG_ADJ_STEPS: adj_steps_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_a_q   <= mul_a_d;
		mul_hi_q  <= mul_hi_d;
		mul_b_q   <= mul_b_d;
		div_rem_q <= div_rem_d;
		div_dsr_q <= div_dsr_d;
		div_quo_q <= div_quo_d;
		dvsr_q    <= dvsr_d;
		cnt_q     <= cnt_d;
		r_q       <= r_d;
		cand_q    <= cand_d;
		act_q     <= act_d;
		strobe_q  <= strobe_d;
		pct_q     <= pct_d;
		v_q       <= v_d;
		m_tdata_q <= m_tdata_d;
	end

	a_idx_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q |-> (idx_q < tot_q))
		else $error("ramp index reached its total while busy");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tot_q != '0)
		else $error("ramp total is zero");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		is_div |-> (div_rem_q < dvsr_q))
		else $error("divider remainder not below divisor");

	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> (m_tdata_q[24:18] <= PCT_FULL))
		else $error("percent above full scale");

endmodule

FILE: tb/eased_brightness_fade_tb.sv
`timescale 1ns / 1ps

module eased_brightness_fade_tb;
	import ebf_pkg::*;

	localparam logic [2:0] ACT_UNDEF_A = 3'd5;
	localparam logic [2:0] ACT_UNDEF_B = 3'd6;
	localparam logic [2:0] ACT_UNDEF_C = 3'd7;
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 200;

	typedef struct {
		logic [2:0]  action;
		logic [15:0] value;
	} fade_item_t;

	typedef struct packed {
		logic [6:0]  pct;
		logic        busy;
		logic        strobe;
		logic [15:0] level;
	} fade_out_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata = '0;
	logic [2:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = '0;
	logic [15:0]      cfg_data = '0;

	fade_item_t  pending_items[$];
	fade_out_t   expected_levels[$];
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// fade state and register copies
	logic [15:0] max_lvl_reg = MAX_LEVEL_RST;
	logic [9:0]  set_steps_reg = SET_STEPS_RST;
	logic [9:0]  adj_steps_reg = ADJ_STEPS_RST;
	logic [15:0] lvl_now = '0;
	logic [15:0] ramp_from = '0;
	logic [15:0] ramp_to = '0;
	logic [9:0]  ramp_pos = '0;
	logic [9:0]  ramp_len = 10'd1;
	logic        ramp_on = 1'b0;

	eased_brightness_fade dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic int unsigned full_scale();
		return (max_lvl_reg == '0) ? 1 : int'(max_lvl_reg);
	endfunction

	function automatic logic [9:0] ramp_ticks(logic [9:0] steps);
		return (steps == '0) ? 10'd1 : steps;
	endfunction

	// cubic ease-out in Q0.16
	function automatic logic [15:0] eased_value(logic [15:0] from, logic [15:0] to,
			logic [9:0] pos, logic [9:0] len, int unsigned limit);
		logic [63:0] half;
		logic [63:0] rem;
		logic [63:0] rem2;
		logic [63:0] rem3;
		logic [63:0] gain;
		logic [63:0] acc;
		half = 64'd1 << (FRAC_W - 1);
		rem  = ((64'(len) - 64'(pos)) << FRAC_W) / 64'(len);
		rem2 = (rem * rem + half) >> FRAC_W;
		rem3 = (rem2 * rem + half) >> FRAC_W;
		gain = (64'd1 << FRAC_W) - rem3;
		acc  = (64'(from) << FRAC_W) + half;
		if (to >= from)
			acc = acc + 64'(to - from) * gain;
		else
			acc = acc - 64'(from - to) * gain;
		acc = acc >> FRAC_W;
		if (acc > 64'(limit))
			acc = 64'(limit);
		return acc[15:0];
	endfunction

	function automatic void start_ramp(int unsigned goal, logic [9:0] steps);
		if (goal == int'(lvl_now)) begin
			ramp_on = 1'b0;
		end else begin
			ramp_from = lvl_now;
			ramp_to   = goal[15:0];
			ramp_pos  = '0;
			ramp_len  = ramp_ticks(steps);
			ramp_on   = 1'b1;
		end
	endfunction

	function automatic void advance_fade(logic [2:0] action, logic [15:0] value);
		int unsigned mx;
		int unsigned pcent;
		int unsigned stride;
		int unsigned goal;
		logic        strobe;
		logic [63:0] share;
		fade_out_t   res;
		mx = full_scale();
		strobe = 1'b0;
		case (action)
			ACT_TICK: begin
				if (ramp_on) begin
					ramp_pos = ramp_pos + 10'd1;
					if (ramp_pos >= ramp_len) begin
						lvl_now = ramp_to;
						ramp_on = 1'b0;
					end else begin
						lvl_now = eased_value(ramp_from, ramp_to, ramp_pos, ramp_len, mx);
					end
					strobe = 1'b1;
				end
			end
			ACT_SET_PCT: begin
				pcent = (value > 16'd100) ? 100 : int'(value);
				start_ramp(mx * pcent / 100, set_steps_reg);
			end
			ACT_STEP_UP, ACT_STEP_DN: begin
				stride = mx / 20;
				if (stride < 1)
					stride = 1;
				if (action == ACT_STEP_UP)
					goal = int'(lvl_now) + stride;
				else
					goal = (int'(lvl_now) > stride) ? int'(lvl_now) - stride : 0;
				if (goal > mx)
					goal = mx;
				start_ramp(goal, adj_steps_reg);
			end
			ACT_SET_RAW: begin
				lvl_now = (int'(value) > mx) ? 16'(mx) : value;
				ramp_on = 1'b0;
				strobe  = 1'b1;
			end
			default: begin
			end
		endcase
		share = 64'(lvl_now) * 64'd100 / 64'(mx);
		if (share > 64'd100)
			share = 64'd100;
		res.level  = lvl_now;
		res.strobe = strobe;
		res.busy   = ramp_on;
		res.pct    = share[6:0];
		expected_levels.push_back(res);
	endfunction

	task automatic push_item(logic [2:0] action, logic [15:0] value);
		fade_item_t it;
		it.action = action;
		it.value  = value;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// mostly a command followed by ticks, the rest noise
	task automatic queue_fade_traffic(int count);
		int          made;
		int          ticks;
		int unsigned span;
		int unsigned mx;
		logic [2:0]  act;
		logic [15:0] arg;
		made = 0;
		while (made < count) begin
			mx = full_scale();
			if ($urandom_range(99) < 70) begin
				case ($urandom_range(3))
					0: act = ACT_SET_PCT;
					1: act = ACT_STEP_UP;
					2: act = ACT_STEP_DN;
					default: act = ACT_SET_RAW;
				endcase
				if ($urandom_range(3) == 0)
					arg = 16'($urandom);
				else if (act == ACT_SET_RAW)
					arg = 16'($urandom_range(0, mx + mx / 4));
				else
					arg = 16'($urandom_range(0, 105));
				push_item(act, arg);
				span = 32'((act == ACT_SET_PCT) ? ramp_ticks(set_steps_reg) :
					ramp_ticks(adj_steps_reg));
				ticks = $urandom_range(1, (span + 1 > 40) ? 40 : span + 1);
				repeat (ticks)
					push_item(ACT_TICK, 16'($urandom));
				made += 1 + ticks;
			end else begin
				act = 3'($urandom_range(7));
				push_item(act, 16'($urandom));
				if (act <= ACT_SET_RAW)
					made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || expected_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_MAX_LEVEL: max_lvl_reg = data;
			REG_SET_STEPS: set_steps_reg = data[9:0];
			REG_ADJ_STEPS: adj_steps_reg = data[9:0];
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : drive_items
		fade_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_fade(s_tuser, s_tdata);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.action;
					s_tdata  <= nxt.value;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_levels
		fade_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_levels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result %h with nothing pending", m_tdata);
				end else begin
					want = expected_levels.pop_front();
					if (m_tdata[15:0] !== want.level || m_tdata[16] !== want.strobe ||
							m_tdata[17] !== want.busy || m_tdata[24:18] !== want.pct ||
							m_tdata[OUT_W-1:25] !== '0) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: got %0d %b %b %0d pad %h, want %0d %b %b %0d",
								m_tdata[15:0], m_tdata[16], m_tdata[17], m_tdata[24:18],
								m_tdata[OUT_W-1:25], want.level, want.strobe, want.busy,
								want.pct);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, no idling
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_item(ACT_TICK, 16'hFFFF);
		push_item(ACT_UNDEF_C, 16'hFFFF);
		push_item(ACT_UNDEF_A, 16'h0000);
		push_item(ACT_UNDEF_B, 16'h1234);
		push_item(ACT_SET_RAW, 16'hFFFF);
		push_item(ACT_SET_PCT, 16'd100);
		push_item(ACT_SET_PCT, 16'hFFFF);
		push_item(ACT_SET_RAW, 16'h0000);
		push_item(ACT_STEP_DN, 16'h0000);
		push_item(ACT_STEP_UP, 16'hA5A5);
		repeat (3) push_item(ACT_TICK, 16'h0000);
		push_item(ACT_STEP_UP, 16'h5A5A);
		repeat (2) push_item(ACT_TICK, 16'h0000);
		push_item(ACT_SET_PCT, 16'd50);
		repeat (2) push_item(ACT_TICK, 16'hFFFF);
		push_item(ACT_STEP_DN, 16'hFFFF);
		push_item(ACT_TICK, 16'h0000);
		queue_fade_traffic(180);
		wait_drained();

		// widest level, longest set ramp, single-tick adjust
		write_reg(REG_MAX_LEVEL, 16'hFFFF);
		write_reg(REG_SET_STEPS, 16'd1023);
		write_reg(REG_ADJ_STEPS, 16'd1);
		send_idle_pct = 62;
		recv_stall_pct = 0;
		queue_fade_traffic(180);
		wait_drained();

		write_reg(REG_MAX_LEVEL, 16'd1000);
		write_reg(REG_SET_STEPS, 16'hFC05);
		write_reg(REG_ADJ_STEPS, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_idle_pct = 0;
		recv_stall_pct = 62;
		queue_fade_traffic(180);
		push_item(ACT_SET_RAW, 16'd1000);
		wait_drained();

		// max dropped below the current level
		write_reg(REG_MAX_LEVEL, 16'd100);
		write_reg(REG_SET_STEPS, 16'h0400);
		write_reg(REG_ADJ_STEPS, 16'd3);
		send_idle_pct = 25;
		recv_stall_pct = 25;
		push_item(ACT_TICK, 16'h0000);
		push_item(ACT_STEP_UP, 16'h0000);
		repeat (3) push_item(ACT_TICK, 16'h0000);
		queue_fade_traffic(180);
		wait_drained();

		write_reg(REG_MAX_LEVEL, 16'h0000);
		write_reg(REG_SET_STEPS, 16'd1);
		write_reg(REG_ADJ_STEPS, 16'd2);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_fade_traffic(180);
		wait_drained();

		write_reg(REG_MAX_LEVEL, 16'd255);
		write_reg(REG_SET_STEPS, 16'd25);
		write_reg(REG_ADJ_STEPS, 16'd12);
		send_idle_pct = 25;
		recv_stall_pct = 25;
		queue_fade_traffic(100);
		wait_drained();
		queue_fade_traffic(100);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_levels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
